// ===== hdl/lswm_pkg.sv =====
`timescale 1ns / 1ps

package lswm_pkg;

    localparam int unsigned CPU_HZ_DEFAULT = 80000000;

    localparam logic [31:0] WINDOW_RESET = 32'd1000;
    localparam logic [31:0] LAT_MIN_RESET = 32'hFFFF_FFFF;
    localparam int US_W = 20;
    localparam logic [US_W-1:0] US_PER_S = 20'd1000000;

    localparam int SUM_W = 64;
    localparam int VAL_W = 32;
    localparam int PROD_W = VAL_W + US_W;
    localparam int STEP_W = $clog2(SUM_W);

    localparam int PADDR_W = 3;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AVG_GO,
        S_AVG_WAIT,
        S_MUL,
        S_CONV_GO,
        S_CONV_WAIT,
        S_HOLD
    } lswm_state_t;

    typedef enum logic [1:0] {
        CONV_AVG,
        CONV_MIN,
        CONV_MAX
    } lswm_conv_t;

    typedef struct packed {
        logic              fire;
        logic [31:0]       msg;
        logic [15:0]       peak;
        logic [31:0]       drops_total;
        logic [31:0]       drops_win;
        logic [31:0]       lat_min;
        logic [31:0]       lat_max;
        logic [SUM_W-1:0]  lat_sum;
        logic [31:0]       lat_cnt;
    } lswm_snap_t;

    typedef struct packed {
        logic busy;
        logic done;
    } lswm_div_stat_t;

endpackage

// ===== hdl/lswm_div.sv =====
`timescale 1ns / 1ps

module lswm_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [lswm_pkg::SUM_W-1:0]      dividend,
    input  logic [lswm_pkg::VAL_W-1:0]      divisor,
    output logic [lswm_pkg::SUM_W-1:0]      quotient,
    output lswm_pkg::lswm_div_stat_t        status
);

    localparam int N = lswm_pkg::SUM_W;
    localparam int D = lswm_pkg::VAL_W;
    localparam logic [lswm_pkg::STEP_W-1:0] LAST_STEP = lswm_pkg::STEP_W'(N - 1);

    logic [N-1:0]                 work_reg;
    logic [N-1:0]                 work_next;
    logic [D-1:0]                 rem_reg;
    logic [D-1:0]                 rem_next;
    logic [D-1:0]                 dvs_reg;
    logic [D-1:0]                 dvs_next;
    logic [lswm_pkg::STEP_W-1:0]  step_reg;
    logic [lswm_pkg::STEP_W-1:0]  step_next;
    logic                         busy_reg;
    logic                         busy_next;
    logic                         done_reg;
    logic                         done_next;

    logic [D:0] rem_shift;
    logic [D:0] rem_diff;
    logic       fits;

    // one restoring step per cycle
    assign rem_shift = {rem_reg, work_reg[N-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign fits      = rem_shift >= {1'b0, dvs_reg};

    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            work_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            work_next = {work_reg[N-2:0], fits};
            rem_next  = fits ? rem_diff[D-1:0] : rem_shift[D-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign quotient    = work_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== hdl/lswm_stats.sv =====
`timescale 1ns / 1ps

module lswm_stats (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   apply,
    input  logic                   depth_valid,
    input  logic [15:0]            queue_depth,
    input  logic                   drop_event,
    input  logic                   message_event,
    input  logic                   latency_valid,
    input  logic [31:0]            latency_cycles,
    input  logic [31:0]            now_tick,
    input  logic                   report_request,
    input  logic [31:0]            window_ticks,
    output lswm_pkg::lswm_snap_t   snap
);

    logic [15:0]                 peak_reg, peak_next;
    logic [31:0]                 drop_total_reg, drop_total_next;
    logic [31:0]                 drop_last_reg, drop_last_next;
    logic [31:0]                 msg_reg, msg_next;
    logic [31:0]                 last_tick_reg, last_tick_next;
    logic [31:0]                 lat_min_reg, lat_min_next;
    logic [31:0]                 lat_max_reg, lat_max_next;
    logic [lswm_pkg::SUM_W-1:0]  lat_sum_reg, lat_sum_next;
    logic [31:0]                 lat_cnt_reg, lat_cnt_next;

    logic [15:0]                 peak_ev;
    logic [31:0]                 drops_ev;
    logic [31:0]                 msg_ev;
    logic [31:0]                 min_ev;
    logic [31:0]                 max_ev;
    logic [lswm_pkg::SUM_W-1:0]  sum_ev;
    logic [31:0]                 cnt_ev;
    logic [31:0]                 elapsed;
    logic                        fire;

    // events first, then the report test
    always_comb
    begin
        peak_ev  = (depth_valid && (queue_depth > peak_reg)) ? queue_depth : peak_reg;
        drops_ev = drop_total_reg + 32'(drop_event);
        msg_ev   = msg_reg + 32'(message_event);
        min_ev   = lat_min_reg;
        max_ev   = lat_max_reg;
        sum_ev   = lat_sum_reg;
        cnt_ev   = lat_cnt_reg;
        if (latency_valid)
        begin
            if (latency_cycles < lat_min_reg)
            begin
                min_ev = latency_cycles;
            end
            if (latency_cycles > lat_max_reg)
            begin
                max_ev = latency_cycles;
            end
            sum_ev = lat_sum_reg + {{(lswm_pkg::SUM_W-32){1'b0}}, latency_cycles};
            cnt_ev = lat_cnt_reg + 32'd1;
        end
        elapsed = now_tick - last_tick_reg;
        fire    = report_request && (elapsed >= window_ticks);
    end

    always_comb
    begin
        peak_next       = peak_reg;
        drop_total_next = drop_total_reg;
        drop_last_next  = drop_last_reg;
        msg_next        = msg_reg;
        last_tick_next  = last_tick_reg;
        lat_min_next    = lat_min_reg;
        lat_max_next    = lat_max_reg;
        lat_sum_next    = lat_sum_reg;
        lat_cnt_next    = lat_cnt_reg;
        if (apply)
        begin
            peak_next       = peak_ev;
            drop_total_next = drops_ev;
            if (fire)
            begin
                msg_next       = '0;
                lat_min_next   = lswm_pkg::LAT_MIN_RESET;
                lat_max_next   = '0;
                lat_sum_next   = '0;
                lat_cnt_next   = '0;
                drop_last_next = drops_ev;
                last_tick_next = now_tick;
            end
            else
            begin
                msg_next     = msg_ev;
                lat_min_next = min_ev;
                lat_max_next = max_ev;
                lat_sum_next = sum_ev;
                lat_cnt_next = cnt_ev;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg       <= '0;
            drop_total_reg <= '0;
            drop_last_reg  <= '0;
            msg_reg        <= '0;
            last_tick_reg  <= '0;
            lat_min_reg    <= lswm_pkg::LAT_MIN_RESET;
            lat_max_reg    <= '0;
            lat_sum_reg    <= '0;
            lat_cnt_reg    <= '0;
        end
        else
        begin
            peak_reg       <= peak_next;
            drop_total_reg <= drop_total_next;
            drop_last_reg  <= drop_last_next;
            msg_reg        <= msg_next;
            last_tick_reg  <= last_tick_next;
            lat_min_reg    <= lat_min_next;
            lat_max_reg    <= lat_max_next;
            lat_sum_reg    <= lat_sum_next;
            lat_cnt_reg    <= lat_cnt_next;
        end
    end

    assign snap.fire        = fire;
    assign snap.msg         = msg_ev;
    assign snap.peak        = peak_ev;
    assign snap.drops_total = drops_ev;
    assign snap.drops_win   = drops_ev - drop_last_reg;
    assign snap.lat_min     = min_ev;
    assign snap.lat_max     = max_ev;
    assign snap.lat_sum     = sum_ev;
    assign snap.lat_cnt     = cnt_ev;

endmodule

// ===== hdl/latency_stats_window_monitor_unit.sv =====
`timescale 1ns / 1ps

// latency statistics window monitor
// input channel (in_valid/in_ready): one item of events plus tick and report request
// output channel (out_valid/out_ready): one record per report that fires
// apb port: window_ticks at offset 0, to be written by the user only while
// the block is idle, which the block itself does not enforce
// an item with no report, or whose window has not elapsed, has its events
// applied at the accepting edge, and in_ready stays high; a firing report
// snapshots the window and clears it on the same edge, then runs one shared
// 64-step restoring divider: mean = sum / count (skipped when count is zero),
// then three conversions (x * 1000000) / CPU_HZ, each after its multiply;
// a report item keeps in_ready low until its record is loaded, and
// out_valid rises in the same cycle that in_ready returns high
// a stalled record holds in the output register; items without reports are
// still taken, and the next report waits at the end of its conversions
// until the output register is free
// reset clears all statistics, min to all ones, window to 1000 ticks

module latency_stats_window_monitor_unit #(
    parameter int unsigned CPU_HZ = lswm_pkg::CPU_HZ_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lswm_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          depth_valid,
    input  logic [15:0]                   queue_depth,
    input  logic                          drop_event,
    input  logic                          message_event,
    input  logic                          latency_valid,
    input  logic [31:0]                   latency_cycles,
    input  logic [31:0]                   now_tick,
    input  logic                          report_request,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [31:0]                   messages_in_window,
    output logic [15:0]                   peak_depth,
    output logic [31:0]                   drops_total,
    output logic [31:0]                   drops_in_window,
    output logic [31:0]                   avg_latency_us,
    output logic [31:0]                   min_latency_us,
    output logic [31:0]                   max_latency_us
);

    localparam logic [31:0] HZ = 32'(CPU_HZ);
    localparam int SUM_W = lswm_pkg::SUM_W;
    localparam int PROD_W = lswm_pkg::PROD_W;

    logic [31:0]                   window_reg;
    logic                          cfg_write;
    logic                          reg_hit;

    lswm_pkg::lswm_snap_t          snap;
    lswm_pkg::lswm_div_stat_t      div_stat;
    logic                          accept;
    logic                          div_start;
    logic [SUM_W-1:0]              div_dividend;
    logic [31:0]                   div_divisor;
    logic [SUM_W-1:0]              div_quotient;
    logic [31:0]                   conv_src;

    lswm_pkg::lswm_state_t         state_reg, state_next;
    lswm_pkg::lswm_conv_t          conv_reg, conv_next;
    logic                          out_valid_reg, out_valid_next;

    logic [31:0]                   msg_reg, msg_next;
    logic [15:0]                   peak_reg, peak_next;
    logic [31:0]                   dtot_reg, dtot_next;
    logic [31:0]                   dwin_reg, dwin_next;
    logic [31:0]                   avg_reg, avg_next;
    logic [31:0]                   min_reg, min_next;
    logic [31:0]                   max_reg, max_next;
    logic [SUM_W-1:0]              sum_reg, sum_next;
    logic [31:0]                   cnt_reg, cnt_next;
    logic [PROD_W-1:0]             prod_reg, prod_next;

    logic [31:0]                   o_msg_reg, o_msg_next;
    logic [15:0]                   o_peak_reg, o_peak_next;
    logic [31:0]                   o_dtot_reg, o_dtot_next;
    logic [31:0]                   o_dwin_reg, o_dwin_next;
    logic [31:0]                   o_avg_reg, o_avg_next;
    logic [31:0]                   o_min_reg, o_min_next;
    logic [31:0]                   o_max_reg, o_max_next;

    // config register
    assign pready    = 1'b1;
    assign reg_hit   = paddr[lswm_pkg::PADDR_W-1:2] == lswm_pkg::REG_WINDOW;
    assign cfg_write = psel && penable && pwrite && reg_hit;
    assign prdata    = reg_hit ? window_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= lswm_pkg::WINDOW_RESET;
        end
        else if (cfg_write)
        begin
            window_reg <= pwdata;
        end
    end

    assign in_ready = state_reg == lswm_pkg::S_IDLE;
    assign accept   = in_valid && in_ready;

    lswm_stats u_stats (
        .clk            (clk),
        .rst_n          (rst_n),
        .apply          (accept),
        .depth_valid    (depth_valid),
        .queue_depth    (queue_depth),
        .drop_event     (drop_event),
        .message_event  (message_event),
        .latency_valid  (latency_valid),
        .latency_cycles (latency_cycles),
        .now_tick       (now_tick),
        .report_request (report_request),
        .window_ticks   (window_reg),
        .snap           (snap)
    );

    assign div_dividend = (state_reg == lswm_pkg::S_AVG_GO) ? sum_reg
                        : {{(SUM_W-PROD_W){1'b0}}, prod_reg};
    assign div_divisor  = (state_reg == lswm_pkg::S_AVG_GO) ? cnt_reg : HZ;

    lswm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_stat)
    );

    always_comb
    begin
        unique case (conv_reg)
            lswm_pkg::CONV_AVG: conv_src = avg_reg;
            lswm_pkg::CONV_MIN: conv_src = min_reg;
            lswm_pkg::CONV_MAX: conv_src = max_reg;
            default:            conv_src = avg_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        conv_next      = conv_reg;
        out_valid_next = out_valid_reg;
        div_start      = 1'b0;
        msg_next       = msg_reg;
        peak_next      = peak_reg;
        dtot_next      = dtot_reg;
        dwin_next      = dwin_reg;
        avg_next       = avg_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        prod_next      = prod_reg;
        o_msg_next     = o_msg_reg;
        o_peak_next    = o_peak_reg;
        o_dtot_next    = o_dtot_reg;
        o_dwin_next    = o_dwin_reg;
        o_avg_next     = o_avg_reg;
        o_min_next     = o_min_reg;
        o_max_next     = o_max_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            lswm_pkg::S_IDLE:
            begin
                if (accept && snap.fire)
                begin
                    msg_next   = snap.msg;
                    peak_next  = snap.peak;
                    dtot_next  = snap.drops_total;
                    dwin_next  = snap.drops_win;
                    min_next   = snap.lat_min;
                    max_next   = snap.lat_max;
                    sum_next   = snap.lat_sum;
                    cnt_next   = snap.lat_cnt;
                    avg_next   = '0;
                    conv_next  = lswm_pkg::CONV_AVG;
                    state_next = (snap.lat_cnt != 32'd0) ? lswm_pkg::S_AVG_GO
                               : lswm_pkg::S_MUL;
                end
            end
            lswm_pkg::S_AVG_GO:
            begin
                div_start  = 1'b1;
                state_next = lswm_pkg::S_AVG_WAIT;
            end
            lswm_pkg::S_AVG_WAIT:
            begin
                if (div_stat.done)
                begin
                    avg_next   = div_quotient[31:0];
                    state_next = lswm_pkg::S_MUL;
                end
            end
            lswm_pkg::S_MUL:
            begin
                prod_next  = PROD_W'(conv_src) * PROD_W'(lswm_pkg::US_PER_S);
                state_next = lswm_pkg::S_CONV_GO;
            end
            lswm_pkg::S_CONV_GO:
            begin
                div_start  = 1'b1;
                state_next = lswm_pkg::S_CONV_WAIT;
            end
            lswm_pkg::S_CONV_WAIT:
            begin
                if (div_stat.done)
                begin
                    unique case (conv_reg)
                        lswm_pkg::CONV_AVG:
                        begin
                            avg_next   = div_quotient[31:0];
                            conv_next  = lswm_pkg::CONV_MIN;
                            state_next = lswm_pkg::S_MUL;
                        end
                        lswm_pkg::CONV_MIN:
                        begin
                            min_next   = div_quotient[31:0];
                            conv_next  = lswm_pkg::CONV_MAX;
                            state_next = lswm_pkg::S_MUL;
                        end
                        default:
                        begin
                            max_next   = div_quotient[31:0];
                            state_next = lswm_pkg::S_HOLD;
                        end
                    endcase
                end
            end
            lswm_pkg::S_HOLD:
            begin
                if (!out_valid_reg)
                begin
                    o_msg_next     = msg_reg;
                    o_peak_next    = peak_reg;
                    o_dtot_next    = dtot_reg;
                    o_dwin_next    = dwin_reg;
                    o_avg_next     = avg_reg;
                    o_min_next     = min_reg;
                    o_max_next     = max_reg;
                    out_valid_next = 1'b1;
                    state_next     = lswm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lswm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lswm_pkg::S_IDLE;
            conv_reg      <= lswm_pkg::CONV_AVG;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            conv_reg      <= conv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        msg_reg    <= msg_next;
        peak_reg   <= peak_next;
        dtot_reg   <= dtot_next;
        dwin_reg   <= dwin_next;
        avg_reg    <= avg_next;
        min_reg    <= min_next;
        max_reg    <= max_next;
        sum_reg    <= sum_next;
        cnt_reg    <= cnt_next;
        prod_reg   <= prod_next;
        o_msg_reg  <= o_msg_next;
        o_peak_reg <= o_peak_next;
        o_dtot_reg <= o_dtot_next;
        o_dwin_reg <= o_dwin_next;
        o_avg_reg  <= o_avg_next;
        o_min_reg  <= o_min_next;
        o_max_reg  <= o_max_next;
    end

    assign out_valid          = out_valid_reg;
    assign messages_in_window = o_msg_reg;
    assign peak_depth         = o_peak_reg;
    assign drops_total        = o_dtot_reg;
    assign drops_in_window    = o_dwin_reg;
    assign avg_latency_us     = o_avg_reg;
    assign min_latency_us     = o_min_reg;
    assign max_latency_us     = o_max_reg;

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_fire_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && snap.fire) |=> (state_reg != lswm_pkg::S_IDLE))
        else $error("report item did not start the sequencer");

    a_hold_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lswm_pkg::S_HOLD && !out_valid_reg) |=> out_valid_reg)
        else $error("record not loaded into free output register");

endmodule

// ===== bench/tb_latency_stats_window_monitor_unit.sv =====
`timescale 1ns / 1ps

module tb_latency_stats_window_monitor_unit;

    localparam int unsigned CLK_HZ = lswm_pkg::CPU_HZ_DEFAULT;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam int unsigned HOLD_CYCLES = 2000;
    localparam int unsigned END_LIMIT = 20000;
    localparam int unsigned PHASE_ITEMS = 236;

    typedef struct {
        bit        has_depth;
        bit [15:0] depth;
        bit        drop;
        bit        message;
        bit        has_latency;
        bit [31:0] latency;
        bit [31:0] now;
        bit        report;
    } mon_item_t;

    typedef struct {
        bit [31:0] messages;
        bit [15:0] peak;
        bit [31:0] drops_total;
        bit [31:0] drops_window;
        bit [31:0] avg_us;
        bit [31:0] min_us;
        bit [31:0] max_us;
    } mon_report_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [lswm_pkg::PADDR_W-1:0]  paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          depth_valid = 1'b0;
    logic [15:0]                   queue_depth = '0;
    logic                          drop_event = 1'b0;
    logic                          message_event = 1'b0;
    logic                          latency_valid = 1'b0;
    logic [31:0]                   latency_cycles = '0;
    logic [31:0]                   now_tick = '0;
    logic                          report_request = 1'b0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [31:0]                   messages_in_window;
    logic [15:0]                   peak_depth;
    logic [31:0]                   drops_total;
    logic [31:0]                   drops_in_window;
    logic [31:0]                   avg_latency_us;
    logic [31:0]                   min_latency_us;
    logic [31:0]                   max_latency_us;

    latency_stats_window_monitor_unit #(
        .CPU_HZ(CLK_HZ)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .depth_valid        (depth_valid),
        .queue_depth        (queue_depth),
        .drop_event         (drop_event),
        .message_event      (message_event),
        .latency_valid      (latency_valid),
        .latency_cycles     (latency_cycles),
        .now_tick           (now_tick),
        .report_request     (report_request),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .messages_in_window (messages_in_window),
        .peak_depth         (peak_depth),
        .drops_total        (drops_total),
        .drops_in_window    (drops_in_window),
        .avg_latency_us     (avg_latency_us),
        .min_latency_us     (min_latency_us),
        .max_latency_us     (max_latency_us)
    );

    // window statistics as the block should hold them
    bit [31:0] window_len = lswm_pkg::WINDOW_RESET;
    bit [15:0] peak_seen = '0;
    bit [31:0] drops_seen = '0;
    bit [31:0] drops_at_report = '0;
    bit [31:0] messages_seen = '0;
    bit [31:0] report_tick = '0;
    bit [31:0] lat_min = lswm_pkg::LAT_MIN_RESET;
    bit [31:0] lat_max = '0;
    bit [63:0] lat_sum = '0;
    bit [31:0] lat_count = '0;

    mon_report_t expected_reports[$];

    bit          steady = 1'b0;
    logic        hold_request = 1'b0;
    int unsigned hold_left = 0;
    bit [31:0]   tick_now = '0;
    int unsigned depth_cap = 64;
    int unsigned items_sent = 0;
    int unsigned records_checked = 0;
    int unsigned window_writes = 0;
    int unsigned mismatches = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit [31:0] latency_in_us(input bit [31:0] cycles);
        bit [63:0] scaled;
        scaled = 64'(cycles) * 64'd1000000;
        return 32'(scaled / 64'(CLK_HZ));
    endfunction

    function automatic void update_window_stats(input mon_item_t it);
        mon_report_t rec;
        bit [31:0]   avg;
        if (it.has_depth && it.depth > peak_seen)
            peak_seen = it.depth;
        if (it.drop)
            drops_seen = drops_seen + 32'd1;
        if (it.message)
            messages_seen = messages_seen + 32'd1;
        if (it.has_latency)
        begin
            if (it.latency < lat_min)
                lat_min = it.latency;
            if (it.latency > lat_max)
                lat_max = it.latency;
            lat_sum = lat_sum + 64'(it.latency);
            lat_count = lat_count + 32'd1;
        end
        if (!it.report || 32'(it.now - report_tick) < window_len)
            return;
        avg = '0;
        if (lat_count != 0)
            avg = 32'(lat_sum / 64'(lat_count));
        rec.messages = messages_seen;
        rec.peak = peak_seen;
        rec.drops_total = drops_seen;
        rec.drops_window = drops_seen - drops_at_report;
        rec.avg_us = latency_in_us(avg);
        rec.min_us = latency_in_us(lat_min);
        rec.max_us = latency_in_us(lat_max);
        expected_reports.push_back(rec);
        messages_seen = '0;
        lat_min = lswm_pkg::LAT_MIN_RESET;
        lat_max = '0;
        lat_sum = '0;
        lat_count = '0;
        drops_at_report = drops_seen;
        report_tick = it.now;
    endfunction

    function automatic mon_item_t make_item(input bit dv, input bit [15:0] depth,
                                            input bit drop, input bit msg,
                                            input bit lv, input bit [31:0] lat,
                                            input bit [31:0] now, input bit req);
        mon_item_t it;
        it.has_depth = dv;
        it.depth = depth;
        it.drop = drop;
        it.message = msg;
        it.has_latency = lv;
        it.latency = lat;
        it.now = now;
        it.report = req;
        return it;
    endfunction

    function automatic mon_item_t random_item();
        mon_item_t   it;
        int unsigned pick;
        int unsigned adv_max;
        it.has_depth = ($urandom_range(99) < 50);
        it.depth = 16'($urandom_range(0, depth_cap));
        it.drop = ($urandom_range(99) < 30);
        it.message = ($urandom_range(99) < 70);
        it.has_latency = ($urandom_range(99) < 60);
        pick = $urandom_range(99);
        if (pick < 50)
            it.latency = $urandom_range(0, 100000);
        else if (pick < 80)
            it.latency = $urandom_range(0, 10000000);
        else if (pick < 95)
            it.latency = $urandom;
        else
            it.latency = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
        // ticks mostly advance at a pace tied to the window, with occasional jumps
        adv_max = (window_len >> 2) + 1;
        pick = $urandom_range(99);
        if (pick < 80)
            tick_now = tick_now + $urandom_range(0, adv_max);
        else if (pick >= 90)
            tick_now = $urandom;
        it.now = tick_now;
        it.report = ($urandom_range(99) < 35);
        if (depth_cap < 65535)
            depth_cap = (depth_cap + 40 > 65535) ? 65535 : depth_cap + 40;
        return it;
    endfunction

    function automatic void count_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endfunction

    function automatic void check_field(input string name, input bit [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
            count_mismatch($sformatf("record %0d %s: expected %0h, got %0h",
                                     records_checked, name, want, got));
    endfunction

    task automatic send_item(input mon_item_t it);
        while (!steady && $urandom_range(99) < 25)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        depth_valid <= it.has_depth;
        queue_depth <= it.depth;
        drop_event <= it.drop;
        message_event <= it.message;
        latency_valid <= it.has_latency;
        latency_cycles <= it.latency;
        now_tick <= it.now;
        report_request <= it.report;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        update_window_stats(it);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input bit [31:0] value);
        wait_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {lswm_pkg::REG_WINDOW, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        window_len = value;
        window_writes++;
    endtask

    // reset window of 1000 ticks: one tick short, then exactly elapsed
    task automatic test_reset_window();
        send_item(make_item(0, 16'hFFFF, 0, 1, 1, 32'd0, 32'd999, 1));
        send_item(make_item(1, 16'd0, 1, 0, 1, 32'd80, 32'd1000, 1));
    endtask

    task automatic test_field_extremes();
        write_window(32'd1);
        send_item(make_item(1, 16'h00FF, 0, 1, 1, 32'hFFFF_FFFF, 32'd1000, 1));
        send_item(make_item(1, 16'd1, 1, 1, 0, 32'hFFFF_FFFF, 32'd1001, 1));
        send_item(make_item(0, 16'd0, 1, 0, 1, 32'd0, 32'd1001, 0));
        send_item(make_item(0, 16'd0, 0, 0, 1, 32'd79_999_999, 32'd1002, 1));
    endtask

    // record with no latency samples, and a request before the window elapsed
    task automatic test_empty_window();
        send_item(make_item(0, 16'd0, 0, 0, 0, 32'd0, 32'd1003, 1));
        send_item(make_item(0, 16'd0, 0, 0, 0, 32'd0, 32'd1003, 1));
        send_item(make_item(0, 16'd0, 1, 1, 0, 32'd0, 32'd1004, 1));
    endtask

    task automatic test_tick_wrap();
        send_item(make_item(1, 16'd2, 0, 1, 1, 32'd1, 32'hFFFF_FFFF, 1));
        send_item(make_item(0, 16'd0, 1, 1, 1, 32'd2, 32'd0, 1));
        write_window(32'hFFFF_FFFF);
        send_item(make_item(0, 16'd0, 0, 1, 1, 32'd160, 32'hFFFF_FFFE, 1));
        send_item(make_item(1, 16'd3, 1, 1, 1, 32'd240, 32'hFFFF_FFFF, 1));
        tick_now = 32'hFFFF_FFFF;
    endtask

    // receiver holds off while every item fires a record, so the block backs up
    task automatic test_output_stall();
        write_window(32'd1);
        hold_request <= 1'b1;
        @(posedge clk);
        hold_request <= 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            tick_now = tick_now + 32'd1;
            send_item(make_item(1, 16'(i * 7), 1, 1, 1, 32'(i * 1000 + 5), tick_now, 1));
        end
        wait_drained();
    endtask

    task automatic test_random_traffic();
        bit [31:0] windows [7];
        windows[0] = 32'd1;
        windows[1] = $urandom_range(2, 64);
        windows[2] = $urandom_range(200, 5000);
        windows[3] = 32'd1000;
        windows[4] = 32'hFFFF_FFFF;
        windows[5] = $urandom;
        windows[6] = 32'h8000_0000;
        if (windows[5] == 0)
            windows[5] = 32'd1;
        for (int p = 0; p < 7; p++)
        begin
            write_window(windows[p]);
            steady = (p == 3);
            repeat (PHASE_ITEMS) send_item(random_item());
        end
        steady = 1'b0;
    endtask

    // peak depth saturates and a later smaller sample leaves it alone
    task automatic test_peak_saturation();
        write_window(32'd1);
        tick_now = tick_now + 32'd1;
        send_item(make_item(1, 16'hFFFF, 0, 1, 1, 32'd12345, tick_now, 1));
        tick_now = tick_now + 32'd1;
        send_item(make_item(1, 16'd0, 1, 0, 0, 32'd0, tick_now, 1));
    endtask

    task automatic finish_run();
        int unsigned waited;
        waited = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_reports.size() != 0 && waited < END_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_reports.size() != 0)
            count_mismatch($sformatf("%0d expected records never arrived",
                                     expected_reports.size()));
        $display("sent %0d items over %0d window settings, checked %0d records",
                 items_sent, window_writes + 1, records_checked);
        $display("covered field extremes, empty windows, tick wrap and output backpressure");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    endtask

    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= steady || ($urandom_range(99) >= 25);
    end

    always @(posedge clk)
    begin : record_check
        mon_report_t want;
        if (out_valid === 1'b1 && out_ready)
        begin
            if (expected_reports.size() == 0)
                count_mismatch($sformatf("record with no expectation waiting: messages %0h",
                                         messages_in_window));
            else
            begin
                want = expected_reports.pop_front();
                check_field("messages_in_window", want.messages, messages_in_window);
                check_field("peak_depth", 32'(want.peak), 32'(peak_depth));
                check_field("drops_total", want.drops_total, drops_total);
                check_field("drops_in_window", want.drops_window, drops_in_window);
                check_field("avg_latency_us", want.avg_us, avg_latency_us);
                check_field("min_latency_us", want.min_us, min_latency_us);
                check_field("max_latency_us", want.max_us, max_latency_us);
                records_checked++;
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_window();
        test_field_extremes();
        test_empty_window();
        test_tick_wrap();
        test_output_stall();
        test_random_traffic();
        test_peak_saturation();
        finish_run();
    end

    initial
    begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
